FILE: rtl/assert_macros.svh
// Shared assertion macros for the ALU RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, disabled while reset is asserted (active low).
`define AST_CHK(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");

// Same check with a caller-supplied message.
`define AST_CHK_MSG(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

`endif

FILE: rtl/c8alu_pkg.sv
`default_nettype none
package c8alu_pkg;

  localparam int unsigned CmdWidth  = 5;
  localparam int unsigned WordWidth = 16;
  localparam int unsigned ByteWidth = 8;
  localparam int unsigned BitIdxW   = 3;
  localparam int unsigned FlagWidth = 4;

  // Flag nibble layout
  localparam int unsigned FlagZ = 3;
  localparam int unsigned FlagN = 2;
  localparam int unsigned FlagH = 1;
  localparam int unsigned FlagC = 0;

  typedef enum logic [CmdWidth-1:0] {
    CMD_ADD    = 5'd0,
    CMD_ADC    = 5'd1,
    CMD_SUB    = 5'd2,
    CMD_SBC    = 5'd3,
    CMD_AND    = 5'd4,
    CMD_OR     = 5'd5,
    CMD_XOR    = 5'd6,
    CMD_CP     = 5'd7,
    CMD_INC    = 5'd8,
    CMD_DEC    = 5'd9,
    CMD_RLC    = 5'd10,
    CMD_RRC    = 5'd11,
    CMD_RL     = 5'd12,
    CMD_RR     = 5'd13,
    CMD_SLA    = 5'd14,
    CMD_SRA    = 5'd15,
    CMD_SRL    = 5'd16,
    CMD_RLCA   = 5'd17,
    CMD_RRCA   = 5'd18,
    CMD_RLA    = 5'd19,
    CMD_RRA    = 5'd20,
    CMD_SWAP   = 5'd21,
    CMD_BIT    = 5'd22,
    CMD_SET    = 5'd23,
    CMD_RES    = 5'd24,
    CMD_CPL    = 5'd25,
    CMD_CCF    = 5'd26,
    CMD_SCF    = 5'd27,
    CMD_ADD_HL = 5'd28,
    CMD_ADD_SP = 5'd29
  } cmd_e;

  typedef struct packed {
    logic [FlagWidth-1:0] flags_in;
    logic [BitIdxW-1:0]   bit_index;
    logic [WordWidth-1:0] second_operand;
    logic [WordWidth-1:0] first_operand;
    cmd_e                 command;
  } alu_req_t;

  typedef struct packed {
    logic                 write_back;
    logic [FlagWidth-1:0] flags_out;
    logic [WordWidth-1:0] result_value;
  } alu_rsp_t;

  localparam int unsigned ReqWidth = $bits(alu_req_t);
  localparam int unsigned RspWidth = $bits(alu_rsp_t);

endpackage
`default_nettype wire

FILE: rtl/cpu8_alu_with_flags_unit.sv
// 8-bit CPU ALU with Z/N/H/C flags: one request per clock cycle unless the master side
// stalls. A request passes through an input register and single-pass combinational ALU
// logic into a result register, from which its result leaves once the master is ready.
// Throughput is one request per cycle without backpressure: each register takes a new
// entry whenever it is empty or being drained, so both sides stream without bubbles.
// Backpressure on the master side stalls the pipe, and the slave side keeps accepting
// while either register has room.
`default_nettype none
`include "assert_macros.svh"
module cpu8_alu_with_flags_unit (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  // tdata: first_operand[15:0], second_operand[31:16], bit_index[34:32],
  //        flags_in[38:35], zero pad[39]
  input  wire logic [39:0] s_axis_tdata_i,
  // tuser: command[4:0]
  input  wire logic [4:0]  s_axis_tuser_i,
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  // tdata: result_value[15:0], flags_out[19:16], write_back[20], zero pad[23:21]
  output logic [23:0]      m_axis_tdata_o
);

  c8alu_pkg::alu_req_t req_in, req_q;
  c8alu_pkg::alu_rsp_t rsp_d, rsp_q;
  logic [c8alu_pkg::ReqWidth-1:0] req_q_bits;
  logic [c8alu_pkg::RspWidth-1:0] rsp_q_bits;
  logic                           req_vld, req_rdy;

  // Unpack the slave-side request.
  assign req_in.command        = c8alu_pkg::cmd_e'(s_axis_tuser_i);
  assign req_in.first_operand  = s_axis_tdata_i[15:0];
  assign req_in.second_operand = s_axis_tdata_i[31:16];
  assign req_in.bit_index      = s_axis_tdata_i[34:32];
  assign req_in.flags_in       = s_axis_tdata_i[38:35];

  // Input register: holds the request while the ALU evaluates it.
  c8alu_pipe_reg #(
    .Width(c8alu_pkg::ReqWidth)
  ) u_req_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .in_data_i  (req_in),
    .out_valid_o(req_vld),
    .out_ready_i(req_rdy),
    .out_data_o (req_q_bits)
  );

  assign req_q = c8alu_pkg::alu_req_t'(req_q_bits);

  // Single-pass ALU between the two registers.
  c8alu_core u_core (
    .req_i(req_q),
    .rsp_o(rsp_d)
  );

  // Result register: parts the ALU from master-side stalls.
  c8alu_pipe_reg #(
    .Width(c8alu_pkg::RspWidth)
  ) u_rsp_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req_vld),
    .in_ready_o (req_rdy),
    .in_data_i  (rsp_d),
    .out_valid_o(m_axis_tvalid_o),
    .out_ready_i(m_axis_tready_i),
    .out_data_o (rsp_q_bits)
  );

  assign rsp_q = c8alu_pkg::alu_rsp_t'(rsp_q_bits);

  // Pack the master-side result, pad to whole bytes.
  assign m_axis_tdata_o = {3'b000, rsp_q.write_back, rsp_q.flags_out, rsp_q.result_value};

  // A result can only appear after a request sat in the input register.
  `AST_CHK_MSG(a_rsp_from_req, clk_i, rst_ni,
    $rose(m_axis_tvalid_o) |-> $past(req_vld), "result without a request")

  // Both registers full and the output stalled: accept nothing.
  `AST_CHK_MSG(a_full_stall, clk_i, rst_ni,
    (m_axis_tvalid_o && !m_axis_tready_i && req_vld) |-> !s_axis_tready_o,
    "request accepted while pipe is full")

  // Flag-only commands never write back and return a zero value.
  `AST_CHK(a_flag_only_no_wb, clk_i, rst_ni,
    (req_vld && (req_q.command == c8alu_pkg::CMD_CP || req_q.command == c8alu_pkg::CMD_BIT ||
      req_q.command == c8alu_pkg::CMD_CCF || req_q.command == c8alu_pkg::CMD_SCF))
      |-> (!rsp_d.write_back && rsp_d.result_value == 16'd0))

  // A stalled result register keeps its contents.
  `AST_CHK(a_rsp_hold, clk_i, rst_ni,
    ($past(m_axis_tvalid_o) && !$past(m_axis_tready_i)) |-> $stable(rsp_q_bits))

endmodule
`default_nettype wire

FILE: rtl/c8alu_pipe_reg.sv
`default_nettype none
module c8alu_pipe_reg #(
  parameter int unsigned Width = 8
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire logic [Width-1:0] in_data_i,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output logic [Width-1:0]      out_data_o
);

  logic             valid_q, valid_d;
  logic [Width-1:0] data_q;
  logic             load;

  // Take a new request when empty or when the held one leaves this cycle.
  assign in_ready_o = !valid_q || out_ready_i;
  assign load       = in_valid_i && in_ready_o;
  assign valid_d    = load ? 1'b1 : (valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      data_q <= in_data_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

endmodule
`default_nettype wire

FILE: rtl/c8alu_core.sv
`default_nettype none
module c8alu_core (
  input  wire c8alu_pkg::alu_req_t req_i,
  output c8alu_pkg::alu_rsp_t      rsp_o
);

  logic [7:0]  a, b;
  logic        cin;
  logic        cin_add, cin_sub;
  logic [8:0]  sum8, diff8;
  logic [4:0]  hsum, hdiff;
  logic [7:0]  inc8, dec8;
  logic [16:0] sum16;
  logic [12:0] sum12;
  logic [15:0] sp_sum;
  logic [8:0]  sp_lo;
  logic [4:0]  sp_h;
  logic [7:0]  bit_mask;
  logic [15:0] res;
  logic [3:0]  fin, fl;
  logic        wb;

  assign a   = req_i.first_operand[7:0];
  assign b   = req_i.second_operand[7:0];
  assign fin = req_i.flags_in;
  assign cin = fin[c8alu_pkg::FlagC];

  assign cin_add = (req_i.command == c8alu_pkg::CMD_ADC) && cin;
  assign cin_sub = (req_i.command == c8alu_pkg::CMD_SBC) && cin;

  assign sum8  = {1'b0, a} + {1'b0, b} + {8'b0, cin_add};
  assign hsum  = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'b0, cin_add};
  // Bit 8 / bit 4 go high on a borrow.
  assign diff8 = {1'b0, a} - {1'b0, b} - {8'b0, cin_sub};
  assign hdiff = {1'b0, a[3:0]} - {1'b0, b[3:0]} - {4'b0, cin_sub};
  assign inc8  = a + 8'd1;
  assign dec8  = a - 8'd1;

  assign sum16  = {1'b0, req_i.first_operand} + {1'b0, req_i.second_operand};
  assign sum12  = {1'b0, req_i.first_operand[11:0]} + {1'b0, req_i.second_operand[11:0]};
  assign sp_sum = req_i.first_operand + {{8{b[7]}}, b};
  assign sp_lo  = {1'b0, req_i.first_operand[7:0]} + {1'b0, b};
  assign sp_h   = {1'b0, req_i.first_operand[3:0]} + {1'b0, b[3:0]};

  assign bit_mask = 8'b1 << req_i.bit_index;

  always_comb begin
    res = '0;
    fl  = fin;
    wb  = 1'b1;
    case (req_i.command)
      c8alu_pkg::CMD_ADD, c8alu_pkg::CMD_ADC: begin
        res = {8'b0, sum8[7:0]};
        fl  = {sum8[7:0] == 8'd0, 1'b0, hsum[4], sum8[8]};
      end
      c8alu_pkg::CMD_SUB, c8alu_pkg::CMD_SBC: begin
        res = {8'b0, diff8[7:0]};
        fl  = {diff8[7:0] == 8'd0, 1'b1, hdiff[4], diff8[8]};
      end
      c8alu_pkg::CMD_CP: begin
        fl = {diff8[7:0] == 8'd0, 1'b1, hdiff[4], diff8[8]};
        wb = 1'b0;
      end
      c8alu_pkg::CMD_AND: begin
        res = {8'b0, a & b};
        fl  = {(a & b) == 8'd0, 1'b0, 1'b1, 1'b0};
      end
      c8alu_pkg::CMD_OR: begin
        res = {8'b0, a | b};
        fl  = {(a | b) == 8'd0, 3'b000};
      end
      c8alu_pkg::CMD_XOR: begin
        res = {8'b0, a ^ b};
        fl  = {(a ^ b) == 8'd0, 3'b000};
      end
      c8alu_pkg::CMD_INC: begin
        res = {8'b0, inc8};
        fl  = {inc8 == 8'd0, 1'b0, inc8[3:0] == 4'h0, cin};
      end
      c8alu_pkg::CMD_DEC: begin
        res = {8'b0, dec8};
        fl  = {dec8 == 8'd0, 1'b1, dec8[3:0] == 4'hf, cin};
      end
      c8alu_pkg::CMD_RLC: begin
        res = {8'b0, a[6:0], a[7]};
        fl  = {a == 8'd0, 2'b00, a[7]};
      end
      c8alu_pkg::CMD_RLCA: begin
        res = {8'b0, a[6:0], a[7]};
        fl  = {3'b000, a[7]};
      end
      c8alu_pkg::CMD_RRC: begin
        res = {8'b0, a[0], a[7:1]};
        fl  = {a == 8'd0, 2'b00, a[0]};
      end
      c8alu_pkg::CMD_RRCA: begin
        res = {8'b0, a[0], a[7:1]};
        fl  = {3'b000, a[0]};
      end
      c8alu_pkg::CMD_RL: begin
        res = {8'b0, a[6:0], cin};
        fl  = {{a[6:0], cin} == 8'd0, 2'b00, a[7]};
      end
      c8alu_pkg::CMD_RLA: begin
        res = {8'b0, a[6:0], cin};
        fl  = {3'b000, a[7]};
      end
      c8alu_pkg::CMD_RR: begin
        res = {8'b0, cin, a[7:1]};
        fl  = {{cin, a[7:1]} == 8'd0, 2'b00, a[0]};
      end
      c8alu_pkg::CMD_RRA: begin
        res = {8'b0, cin, a[7:1]};
        fl  = {3'b000, a[0]};
      end
      c8alu_pkg::CMD_SLA: begin
        res = {8'b0, a[6:0], 1'b0};
        fl  = {a[6:0] == 7'd0, 2'b00, a[7]};
      end
      c8alu_pkg::CMD_SRA: begin
        res = {8'b0, a[7], a[7:1]};
        fl  = {a[7:1] == 7'd0, 2'b00, a[0]};
      end
      c8alu_pkg::CMD_SRL: begin
        res = {8'b0, 1'b0, a[7:1]};
        fl  = {a[7:1] == 7'd0, 2'b00, a[0]};
      end
      c8alu_pkg::CMD_SWAP: begin
        res = {8'b0, a[3:0], a[7:4]};
        fl  = {a == 8'd0, 3'b000};
      end
      c8alu_pkg::CMD_BIT: begin
        fl = {(a & bit_mask) == 8'd0, 1'b0, 1'b1, cin};
        wb = 1'b0;
      end
      c8alu_pkg::CMD_SET: begin
        res = {8'b0, a | bit_mask};
      end
      c8alu_pkg::CMD_RES: begin
        res = {8'b0, a & ~bit_mask};
      end
      c8alu_pkg::CMD_CPL: begin
        res = {8'b0, ~a};
        fl  = {fin[c8alu_pkg::FlagZ], 1'b1, 1'b1, cin};
      end
      c8alu_pkg::CMD_CCF: begin
        fl = {fin[c8alu_pkg::FlagZ], 2'b00, !cin};
        wb = 1'b0;
      end
      c8alu_pkg::CMD_SCF: begin
        fl = {fin[c8alu_pkg::FlagZ], 2'b00, 1'b1};
        wb = 1'b0;
      end
      c8alu_pkg::CMD_ADD_HL: begin
        res = sum16[15:0];
        fl  = {fin[c8alu_pkg::FlagZ], 1'b0, sum12[12], sum16[16]};
      end
      c8alu_pkg::CMD_ADD_SP: begin
        res = sp_sum;
        fl  = {2'b00, sp_h[4], sp_lo[8]};
      end
      default: begin
        // Undefined codes: flags pass through, nothing stored.
        wb = 1'b0;
      end
    endcase
  end

  assign rsp_o.result_value = res;
  assign rsp_o.flags_out    = fl;
  assign rsp_o.write_back   = wb;

endmodule
`default_nettype wire

FILE: bench/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

  // Opcodes the block leaves undefined: flags pass through, nothing is written.
  localparam logic [c8alu_pkg::CmdWidth-1:0] CmdSpareLo = 5'd30;
  localparam logic [c8alu_pkg::CmdWidth-1:0] CmdSpareHi = 5'd31;

  localparam int unsigned CycleLimit  = 600000;
  localparam int unsigned SettleTicks = 8;

  typedef struct {
    logic [c8alu_pkg::CmdWidth-1:0]  cmd;
    logic [c8alu_pkg::WordWidth-1:0] x;
    logic [c8alu_pkg::WordWidth-1:0] y;
    logic [c8alu_pkg::BitIdxW-1:0]   bit_sel;
    logic [c8alu_pkg::FlagWidth-1:0] flags;
  } alu_op_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid_i;
  logic        s_axis_tready_o;
  // tdata: first_operand[15:0], second_operand[31:16], bit_index[34:32],
  //        flags_in[38:35], zero pad[39]
  logic [39:0] s_axis_tdata_i;
  // tuser: command[4:0]
  logic [4:0]  s_axis_tuser_i;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i;
  // tdata: result_value[15:0], flags_out[19:16], write_back[20], zero pad[23:21]
  logic [23:0] m_axis_tdata_o;

  c8alu_pkg::alu_rsp_t pending_results[$];
  int unsigned         error_count;
  int unsigned         results_seen;
  int unsigned         cycle_count;
  bit                  idling_on;

  cpu8_alu_with_flags_unit uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic logic [c8alu_pkg::FlagWidth-1:0] pack_flags(input logic z,
                                                                 input logic n,
                                                                 input logic h,
                                                                 input logic c);
    logic [c8alu_pkg::FlagWidth-1:0] f;
    f                   = '0;
    f[c8alu_pkg::FlagZ] = z;
    f[c8alu_pkg::FlagN] = n;
    f[c8alu_pkg::FlagH] = h;
    f[c8alu_pkg::FlagC] = c;
    return f;
  endfunction

  // Expected result of one ALU request.
  function automatic c8alu_pkg::alu_rsp_t predict_alu(input alu_op_t op);
    c8alu_pkg::alu_rsp_t r;
    logic [7:0]  a, b, res8;
    logic [8:0]  wide9;
    logic [4:0]  nib;
    logic [12:0] low13;
    logic [16:0] sum17;
    logic        cin, carry, byte_op;
    a       = op.x[7:0];
    b       = op.y[7:0];
    cin     = op.flags[c8alu_pkg::FlagC];
    res8    = '0;
    byte_op = 1'b1;
    r.result_value = '0;
    r.flags_out    = op.flags;
    r.write_back   = 1'b1;
    case (op.cmd)
      c8alu_pkg::CMD_ADD, c8alu_pkg::CMD_ADC: begin
        carry = (op.cmd == c8alu_pkg::CMD_ADC) ? cin : 1'b0;
        wide9 = {1'b0, a} + {1'b0, b} + {8'h00, carry};
        nib   = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'h0, carry};
        res8  = wide9[7:0];
        r.flags_out = pack_flags(res8 == 8'h00, 1'b0, nib[4], wide9[8]);
      end
      c8alu_pkg::CMD_SUB, c8alu_pkg::CMD_SBC, c8alu_pkg::CMD_CP: begin
        carry = (op.cmd == c8alu_pkg::CMD_SBC) ? cin : 1'b0;
        wide9 = {1'b0, a} - {1'b0, b} - {8'h00, carry};
        nib   = {1'b0, a[3:0]} - {1'b0, b[3:0]} - {4'h0, carry};
        res8  = wide9[7:0];
        r.flags_out = pack_flags(res8 == 8'h00, 1'b1, nib[4], wide9[8]);
        // compare only sets flags
        if (op.cmd == c8alu_pkg::CMD_CP) begin
          res8         = '0;
          r.write_back = 1'b0;
        end
      end
      c8alu_pkg::CMD_AND: begin
        res8        = a & b;
        r.flags_out = pack_flags(res8 == 8'h00, 1'b0, 1'b1, 1'b0);
      end
      c8alu_pkg::CMD_OR, c8alu_pkg::CMD_XOR: begin
        res8        = (op.cmd == c8alu_pkg::CMD_OR) ? (a | b) : (a ^ b);
        r.flags_out = pack_flags(res8 == 8'h00, 1'b0, 1'b0, 1'b0);
      end
      c8alu_pkg::CMD_INC: begin
        res8        = a + 8'h01;
        r.flags_out = pack_flags(res8 == 8'h00, 1'b0, res8[3:0] == 4'h0, cin);
      end
      c8alu_pkg::CMD_DEC: begin
        res8        = a - 8'h01;
        r.flags_out = pack_flags(res8 == 8'h00, 1'b1, res8[3:0] == 4'hF, cin);
      end
      // accumulator forms of the rotates always clear Z
      c8alu_pkg::CMD_RLC, c8alu_pkg::CMD_RLCA: begin
        res8        = {a[6:0], a[7]};
        r.flags_out = pack_flags(op.cmd == c8alu_pkg::CMD_RLC && res8 == 8'h00,
                                 1'b0, 1'b0, a[7]);
      end
      c8alu_pkg::CMD_RRC, c8alu_pkg::CMD_RRCA: begin
        res8        = {a[0], a[7:1]};
        r.flags_out = pack_flags(op.cmd == c8alu_pkg::CMD_RRC && res8 == 8'h00,
                                 1'b0, 1'b0, a[0]);
      end
      c8alu_pkg::CMD_RL, c8alu_pkg::CMD_RLA: begin
        res8        = {a[6:0], cin};
        r.flags_out = pack_flags(op.cmd == c8alu_pkg::CMD_RL && res8 == 8'h00,
                                 1'b0, 1'b0, a[7]);
      end
      c8alu_pkg::CMD_RR, c8alu_pkg::CMD_RRA: begin
        res8        = {cin, a[7:1]};
        r.flags_out = pack_flags(op.cmd == c8alu_pkg::CMD_RR && res8 == 8'h00,
                                 1'b0, 1'b0, a[0]);
      end
      c8alu_pkg::CMD_SLA: begin
        res8        = {a[6:0], 1'b0};
        r.flags_out = pack_flags(res8 == 8'h00, 1'b0, 1'b0, a[7]);
      end
      c8alu_pkg::CMD_SRA, c8alu_pkg::CMD_SRL: begin
        res8        = {(op.cmd == c8alu_pkg::CMD_SRA) ? a[7] : 1'b0, a[7:1]};
        r.flags_out = pack_flags(res8 == 8'h00, 1'b0, 1'b0, a[0]);
      end
      c8alu_pkg::CMD_SWAP: begin
        res8        = {a[3:0], a[7:4]};
        r.flags_out = pack_flags(res8 == 8'h00, 1'b0, 1'b0, 1'b0);
      end
      c8alu_pkg::CMD_BIT: begin
        r.flags_out  = pack_flags(!a[op.bit_sel], 1'b0, 1'b1, cin);
        r.write_back = 1'b0;
      end
      c8alu_pkg::CMD_SET: res8 = a | (8'h01 << op.bit_sel);
      c8alu_pkg::CMD_RES: res8 = a & ~(8'h01 << op.bit_sel);
      c8alu_pkg::CMD_CPL: begin
        res8        = ~a;
        r.flags_out = pack_flags(op.flags[c8alu_pkg::FlagZ], 1'b1, 1'b1, cin);
      end
      c8alu_pkg::CMD_CCF: begin
        r.flags_out  = pack_flags(op.flags[c8alu_pkg::FlagZ], 1'b0, 1'b0, !cin);
        r.write_back = 1'b0;
      end
      c8alu_pkg::CMD_SCF: begin
        r.flags_out  = pack_flags(op.flags[c8alu_pkg::FlagZ], 1'b0, 1'b0, 1'b1);
        r.write_back = 1'b0;
      end
      c8alu_pkg::CMD_ADD_HL: begin
        byte_op        = 1'b0;
        sum17          = {1'b0, op.x} + {1'b0, op.y};
        low13          = {1'b0, op.x[11:0]} + {1'b0, op.y[11:0]};
        r.result_value = sum17[15:0];
        r.flags_out    = pack_flags(op.flags[c8alu_pkg::FlagZ], 1'b0, low13[12], sum17[16]);
      end
      c8alu_pkg::CMD_ADD_SP: begin
        // signed offset, carries taken from the unsigned low byte
        byte_op        = 1'b0;
        nib            = {1'b0, op.x[3:0]} + {1'b0, b[3:0]};
        wide9          = {1'b0, op.x[7:0]} + {1'b0, b};
        r.result_value = op.x + {{8{b[7]}}, b};
        r.flags_out    = pack_flags(1'b0, 1'b0, nib[4], wide9[8]);
      end
      default: r.write_back = 1'b0;
    endcase
    if (byte_op) r.result_value = {8'h00, res8};
    return r;
  endfunction

  function automatic alu_op_t mk_op(input logic [c8alu_pkg::CmdWidth-1:0] cmd,
                                    input logic [15:0] x, input logic [15:0] y,
                                    input logic [2:0] bit_sel, input logic [3:0] flags);
    alu_op_t op;
    op.cmd     = cmd;
    op.x       = x;
    op.y       = y;
    op.bit_sel = bit_sel;
    op.flags   = flags;
    return op;
  endfunction

  // Mostly no gap, some short, a few long.
  function automatic int unsigned idle_cycles();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (!idling_on || roll < 55) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Random word whose low byte often sits on a corner value.
  function automatic logic [15:0] corner_word();
    logic [15:0] w;
    w = 16'($urandom);
    case ($urandom_range(0, 7))
      0: w[7:0] = 8'h00;
      1: w[7:0] = 8'hFF;
      2: w[7:0] = 8'h80;
      3: w[7:0] = 8'h7F;
      4: w[7:0] = 8'h0F;
      default: ;
    endcase
    return w;
  endfunction

  function automatic alu_op_t random_op();
    return mk_op(5'($urandom_range(0, (1 << c8alu_pkg::CmdWidth) - 1)), corner_word(),
                 corner_word(), 3'($urandom_range(0, 7)), 4'($urandom_range(0, 15)));
  endfunction

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch on result %0d: %s", $realtime, results_seen, msg);
    error_count++;
  endtask

  // Present one request, hold it until accepted, then queue its expected result.
  task automatic send_op(input alu_op_t op);
    int unsigned gap;
    gap = idle_cycles();
    if (gap != 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i  <= op.cmd;
    s_axis_tdata_i  <= {1'b0, op.flags, op.bit_sel, op.y, op.x};
    do @(posedge clk_i); while (!s_axis_tready_o);
    pending_results.push_back(predict_alu(op));
  endtask

  // Drop valid and hold until every queued result has come back.
  task automatic wait_for_results();
    s_axis_tvalid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic test_command_corners();
    send_op(mk_op(c8alu_pkg::CMD_ADD,    16'hAB3A, 16'hCDC6, 3'd0, 4'h0)); // zero, H and C
    send_op(mk_op(c8alu_pkg::CMD_ADC,    16'h000F, 16'hFF00, 3'd0, 4'h1)); // carry in, H
    send_op(mk_op(c8alu_pkg::CMD_SUB,    16'h0000, 16'h0001, 3'd0, 4'h0)); // borrow
    send_op(mk_op(c8alu_pkg::CMD_SBC,    16'h0010, 16'h000F, 3'd0, 4'h1)); // zero with H
    send_op(mk_op(c8alu_pkg::CMD_CP,     16'h0042, 16'h0042, 3'd0, 4'h0)); // flags only
    send_op(mk_op(c8alu_pkg::CMD_AND,    16'h00F0, 16'h000F, 3'd0, 4'hF));
    send_op(mk_op(c8alu_pkg::CMD_OR,     16'hFF00, 16'hFF00, 3'd0, 4'h0));
    send_op(mk_op(c8alu_pkg::CMD_XOR,    16'h00FF, 16'h00FF, 3'd0, 4'h0));
    send_op(mk_op(c8alu_pkg::CMD_INC,    16'h00FF, 16'h0000, 3'd0, 4'h1)); // wraps, keeps C
    send_op(mk_op(c8alu_pkg::CMD_DEC,    16'h0000, 16'h0000, 3'd0, 4'h0)); // wraps, H
    send_op(mk_op(c8alu_pkg::CMD_DEC,    16'h0001, 16'h0000, 3'd0, 4'h1));
    send_op(mk_op(c8alu_pkg::CMD_RLC,    16'h0080, 16'h0000, 3'd0, 4'h0));
    send_op(mk_op(c8alu_pkg::CMD_RRC,    16'h0001, 16'h0000, 3'd0, 4'h0));
    send_op(mk_op(c8alu_pkg::CMD_RL,     16'h0080, 16'h0000, 3'd0, 4'h0)); // zero result
    send_op(mk_op(c8alu_pkg::CMD_RR,     16'h0001, 16'h0000, 3'd0, 4'h1));
    send_op(mk_op(c8alu_pkg::CMD_SLA,    16'h0080, 16'h0000, 3'd0, 4'h0));
    send_op(mk_op(c8alu_pkg::CMD_SRA,    16'h0081, 16'h0000, 3'd0, 4'h0));
    send_op(mk_op(c8alu_pkg::CMD_SRL,    16'h0001, 16'h0000, 3'd0, 4'hF));
    // accumulator form clears Z
    send_op(mk_op(c8alu_pkg::CMD_RLCA,   16'h0000, 16'h0000, 3'd0, 4'hF));
    send_op(mk_op(c8alu_pkg::CMD_RRCA,   16'h0001, 16'h0000, 3'd0, 4'h0));
    send_op(mk_op(c8alu_pkg::CMD_RLA,    16'h0080, 16'h0000, 3'd0, 4'h0));
    send_op(mk_op(c8alu_pkg::CMD_RRA,    16'h0001, 16'h0000, 3'd0, 4'h0));
    send_op(mk_op(c8alu_pkg::CMD_SWAP,   16'h00F0, 16'h0000, 3'd0, 4'hF));
    send_op(mk_op(c8alu_pkg::CMD_SWAP,   16'hFF00, 16'h0000, 3'd0, 4'h0));
    send_op(mk_op(c8alu_pkg::CMD_BIT,    16'h007F, 16'h0000, 3'd7, 4'h1));
    send_op(mk_op(c8alu_pkg::CMD_BIT,    16'h0001, 16'h0000, 3'd0, 4'h0));
    send_op(mk_op(c8alu_pkg::CMD_SET,    16'h0000, 16'h0000, 3'd7, 4'hA));
    send_op(mk_op(c8alu_pkg::CMD_RES,    16'h00FF, 16'h0000, 3'd0, 4'h5));
    send_op(mk_op(c8alu_pkg::CMD_CPL,    16'h005A, 16'h0000, 3'd0, 4'h9));
    send_op(mk_op(c8alu_pkg::CMD_CCF,    16'h0000, 16'h0000, 3'd0, 4'hF));
    send_op(mk_op(c8alu_pkg::CMD_SCF,    16'h0000, 16'h0000, 3'd0, 4'h6));
    send_op(mk_op(c8alu_pkg::CMD_ADD_HL, 16'h0FFF, 16'h0001, 3'd0, 4'h8)); // H from bit 11
    send_op(mk_op(c8alu_pkg::CMD_ADD_HL, 16'hFFFF, 16'h0001, 3'd0, 4'h0)); // full carry
    // upper offset bits ignored
    send_op(mk_op(c8alu_pkg::CMD_ADD_SP, 16'h00FF, 16'hAB01, 3'd0, 4'hF));
    send_op(mk_op(c8alu_pkg::CMD_ADD_SP, 16'h0000, 16'h00FF, 3'd0, 4'h0)); // minus one
    send_op(mk_op(CmdSpareLo,            16'hFFFF, 16'hFFFF, 3'd7, 4'hA));
    send_op(mk_op(CmdSpareHi,            16'h1234, 16'h5678, 3'd3, 4'h5));
  endtask

  // Random mix of every opcode; stop halfway and let the pipe run dry once.
  task automatic test_random_ops(input int unsigned count);
    for (int unsigned i = 0; i < count; i++) begin
      if (i == count / 2) wait_for_results();
      send_op(random_op());
    end
  endtask

  // Neither side idles: back-to-back requests through a full pipe.
  task automatic test_streaming_no_idle(input int unsigned count);
    idling_on = 1'b0;
    for (int unsigned i = 0; i < count; i++) send_op(random_op());
    idling_on = 1'b1;
  endtask

  // 16-bit adds with operands placed near the bit 3, 7, 11 and 15 carry edges.
  task automatic test_wide_adds(input int unsigned count);
    alu_op_t op;
    for (int unsigned i = 0; i < count; i++) begin
      op     = random_op();
      op.cmd = ($urandom_range(0, 1) != 0) ? c8alu_pkg::CMD_ADD_HL : c8alu_pkg::CMD_ADD_SP;
      case ($urandom_range(0, 3))
        0: op.x[11:0] = 12'hFFF - 12'($urandom_range(0, 3));
        1: op.x[3:0]  = 4'hF;
        2: op.x       = 16'hFFFF - 16'($urandom_range(0, 3));
        default: ;
      endcase
      send_op(op);
    end
  endtask

  // Compare each returned result against the oldest pending prediction.
  always @(posedge clk_i) begin : result_check
    c8alu_pkg::alu_rsp_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result, data %h", m_axis_tdata_o));
      end else begin
        want = pending_results.pop_front();
        if (m_axis_tdata_o[15:0] !== want.result_value)
          report_mismatch($sformatf("result_value got %h want %h",
                                    m_axis_tdata_o[15:0], want.result_value));
        if (m_axis_tdata_o[19:16] !== want.flags_out)
          report_mismatch($sformatf("flags_out got %b want %b",
                                    m_axis_tdata_o[19:16], want.flags_out));
        if (m_axis_tdata_o[20] !== want.write_back)
          report_mismatch($sformatf("write_back got %b want %b",
                                    m_axis_tdata_o[20], want.write_back));
      end
      results_seen++;
    end
  end

  // Result side backpressure: ready runs broken by stalls of random length.
  initial begin : sink_stall
    int unsigned run_len, stall_len;
    m_axis_tready_i <= 1'b0;
    @(posedge clk_i);
    forever begin
      run_len = $urandom_range(1, 40);
      m_axis_tready_i <= 1'b1;
      repeat (run_len) @(posedge clk_i);
      stall_len = idle_cycles();
      if (stall_len != 0) begin
        m_axis_tready_i <= 1'b0;
        repeat (stall_len) @(posedge clk_i);
      end
    end
  end

  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("cpu8_alu_with_flags_unit verification failed");
    $finish;
  end

  initial begin
    error_count     = 0;
    results_seen    = 0;
    idling_on       = 1'b1;
    rst_ni          <= 1'b0;
    s_axis_tvalid_i <= 1'b0;
    s_axis_tdata_i  <= '0;
    s_axis_tuser_i  <= '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_command_corners();
    test_random_ops(1250);
    test_streaming_no_idle(200);
    test_wide_adds(200);

    wait_for_results();
    // let any stray result surface before the verdict
    repeat (SettleTicks) @(posedge clk_i);
    if (error_count == 0) begin
      $display("cpu8_alu_with_flags_unit verification clean");
    end else begin
      $display("cpu8_alu_with_flags_unit verification failed");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+rtl
rtl/c8alu_pkg.sv
rtl/c8alu_pipe_reg.sv
rtl/c8alu_core.sv
rtl/cpu8_alu_with_flags_unit.sv
bench/tb_top.sv
